### hw/rtl/hgns_pkg.sv
// Shared types, constants and helper functions of the Halton Gaussian noise sampler.
package hgns_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int DIM_W      = 2;
    localparam int IDX_W      = 32;
    localparam int FX         = 24;
    localparam int SIGMA_W    = 24;
    localparam int COEF_W     = 17;
    localparam int VAL_W      = 32;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 35;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA3    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_OFS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 3'd7;

    // Request opcodes.
    localparam logic OP_PRODUCE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [2:0]         RST_DIM_COUNT = 3'd2;
    localparam logic [SIGMA_W-1:0] RST_SIGMA     = 24'd65536;
    localparam logic [COEF_W-1:0]  RST_DECAY     = 17'd0;
    localparam logic [COEF_W-1:0]  RST_DIFFUSION = 17'd65536;

    // Inverse-normal constants in Q.24, and 2*ln2 in Q.32.
    localparam logic [MUL_W-1:0] TWO_LN2 = 33'd5954088944;
    localparam logic [ACC_W-1:0] K_C0    = 35'd42203372;
    localparam logic [ACC_W-1:0] ONE_Q24 = 35'd16777216;
    localparam logic [MUL_W-1:0] K_C1    = 33'd13469638;
    localparam logic [MUL_W-1:0] K_C2    = 33'd173275;
    localparam logic [MUL_W-1:0] K_D1    = 33'd24038194;
    localparam logic [MUL_W-1:0] K_D2    = 33'd3175407;
    localparam logic [MUL_W-1:0] K_D3    = 33'd21945;

    localparam logic [4:0] POLY_LAST = 5'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_DIM_START, S_RAD_MUL, S_RAD_DIG, S_DIV_INIT, S_DIV, S_INV_PREP,
        S_NORM, S_SQ_MUL, S_SQ_POST, S_LN_MUL, S_LN_POST, S_SQRT, S_POLY, S_FIN,
        S_SIG_MUL, S_SIG_POST, S_BL1, S_BL2, S_BL3, S_BL_RND, S_EMIT
    } t_state;

    // Row request from the stream front end to the core.
    typedef struct packed {
        logic             start;
        logic             first;
        logic [IDX_W-1:0] idx;
        logic [DIM_W-1:0] last_dim;
    } t_core_cmd;

    // Result and status from the core.
    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] dim;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             idle;
    } t_core_res;

    // Prime base of a dimension.
    function automatic logic [ACC_W-1:0] prime_of(input logic [DIM_W-1:0] d);
        logic [ACC_W-1:0] p;
        begin
            case (d)
                2'd0:    p = 35'd2;
                2'd1:    p = 35'd3;
                2'd2:    p = 35'd5;
                default: p = 35'd7;
            endcase
            return p;
        end
    endfunction

    // floor(2^32 / base), the reciprocal used for digit extraction.
    function automatic logic [MUL_W-1:0] magic_of(input logic [DIM_W-1:0] d);
        logic [MUL_W-1:0] m;
        begin
            case (d)
                2'd0:    m = 33'd2147483648;
                2'd1:    m = 33'd1431655765;
                2'd2:    m = 33'd858993459;
                default: m = 33'd613566756;
            endcase
            return m;
        end
    endfunction

    // Multiply by the small prime base with shifts and adds.
    function automatic logic [ACC_W-1:0] mul_small(input logic [ACC_W-1:0] v,
                                                   input logic [DIM_W-1:0] d);
        logic [ACC_W-1:0] r;
        begin
            case (d)
                2'd0:    r = v << 1;
                2'd1:    r = (v << 1) + v;
                2'd2:    r = (v << 2) + v;
                default: r = (v << 3) - v;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/halton_gaussian_noise_sampler_unit.sv
// Top level: stream ports, configuration registers, row counter and output register.
// Each dimension runs the radical-inverse digits, two 32-step divisions, normalize, 24
// squarings and a 28-step square root; a row holds 1 to 4 dimensions.
// A new request is accepted only while the core sequencer is idle, so one row is worked on at a time.
// A clear request only resets the row counter and gives no result.
// Reset (synchronous, active low) clears the row counter, the previous row and all control
// state, and loads the configuration registers with their defaults.
module halton_gaussian_noise_sampler_unit
    import hgns_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // [0] opcode, [7:1] zero
    input  logic                  i_s_axis_tuser,  // [0] first_row
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [VAL_W-1:0]      o_m_axis_tdata,  // [31:0] noise_value
    output logic [DIM_W-1:0]      o_m_axis_tuser,  // [1:0] dim_index
    output logic                  o_m_axis_tlast,  // last_of_row
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [2:0]                      r_dim_count;
    logic [MAX_DIMS-1:0][SIGMA_W-1:0] r_sigma;
    logic [CFG_DATA_W-1:0]           r_seq_offset;
    logic [COEF_W-1:0]               r_decay, r_diffusion;
    logic [IDX_W-1:0]                r_row_cnt;
    logic                            r_m_valid, r_m_last;
    logic [VAL_W-1:0]                r_m_data;
    logic [DIM_W-1:0]                r_m_user;

    t_core_cmd core_cmd;
    t_core_res core_res;
    logic      in_fire, emit_ready;
    logic [DIM_W-1:0] last_dim;

    assign o_s_axis_tready = core_res.idle;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign emit_ready      = !r_m_valid || i_m_axis_tready;

    // Active dimension count, with zero acting as one and large values as the maximum.
    always_comb begin
        if (r_dim_count == 3'd0) begin
            last_dim = '0;
        end else if (r_dim_count > 3'(MAX_DIMS)) begin
            last_dim = 2'(MAX_DIMS - 1);
        end else begin
            last_dim = 2'(r_dim_count - 3'd1);
        end
        core_cmd.start    = in_fire && (i_s_axis_tdata[0] == OP_PRODUCE);
        core_cmd.first    = i_s_axis_tuser;
        core_cmd.idx      = {1'b0, r_seq_offset} + r_row_cnt;
        core_cmd.last_dim = last_dim;
    end

    hgns_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (core_cmd),
        .i_sigma      (r_sigma),
        .i_decay      (r_decay),
        .i_diffusion  (r_diffusion),
        .i_emit_ready (emit_ready),
        .o_res        (core_res)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count  <= RST_DIM_COUNT;
            r_sigma      <= {MAX_DIMS{RST_SIGMA}};
            r_seq_offset <= '0;
            r_decay      <= RST_DECAY;
            r_diffusion  <= RST_DIFFUSION;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIM_COUNT: r_dim_count  <= i_cfg_wdata[2:0];
                CFG_SIGMA0:    r_sigma[0]   <= i_cfg_wdata[SIGMA_W-1:0];
                CFG_SIGMA1:    r_sigma[1]   <= i_cfg_wdata[SIGMA_W-1:0];
                CFG_SIGMA2:    r_sigma[2]   <= i_cfg_wdata[SIGMA_W-1:0];
                CFG_SIGMA3:    r_sigma[3]   <= i_cfg_wdata[SIGMA_W-1:0];
                CFG_SEQ_OFS:   r_seq_offset <= i_cfg_wdata;
                CFG_DECAY:     r_decay      <= i_cfg_wdata[COEF_W-1:0];
                CFG_DIFFUSION: r_diffusion  <= i_cfg_wdata[COEF_W-1:0];
                default:       r_dim_count  <= r_dim_count;
            endcase
        end
    end

    // Row counter: cleared by a clear request, advanced by each produce request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
        end else if (in_fire) begin
            if (i_s_axis_tdata[0] == OP_CLEAR) r_row_cnt <= '0;
            else r_row_cnt <= r_row_cnt + 32'd1;
        end
    end

    // Output register between the core and the master port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit_ready) begin
            r_m_valid <= core_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ready && core_res.valid) begin
            r_m_data <= core_res.value;
            r_m_user <= core_res.dim;
            r_m_last <= core_res.last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;
    assign o_m_axis_tlast  = r_m_last;

endmodule

### hw/rtl/hgns_mul.sv
// Shared unsigned multiplier with a registered product.
module hgns_mul
    import hgns_pkg::*;
(
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= {{(PROD_W-MUL_W){1'b0}}, i_a} * {{(PROD_W-MUL_W){1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/hgns_core.sv
// Sequencer and datapath that turn a sequence index into one noise value per dimension.
module hgns_core
    import hgns_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_core_cmd                        i_cmd,
    input  logic [MAX_DIMS-1:0][SIGMA_W-1:0] i_sigma,
    input  logic [COEF_W-1:0]                i_decay,
    input  logic [COEF_W-1:0]                i_diffusion,
    input  logic                             i_emit_ready,
    output t_core_res                        o_res
);

    t_state r_state, n_state;

    logic [DIM_W-1:0]  r_dim, n_dim, r_last_dim, n_last_dim;
    logic              r_first, n_first, r_phase, n_phase, r_neg, n_neg, r_zneg, n_zneg;
    logic [IDX_W-1:0]  r_idx, n_idx, r_x, n_x, r_dlow, n_dlow, r_quo, n_quo;
    logic [ACC_W-1:0]  r_num, n_num, r_den, n_den;
    logic [ACC_W:0]    r_rem, n_rem;
    logic [4:0]        r_cnt, n_cnt, r_e, n_e;
    logic [31:0]       r_m, n_m, r_mag, n_mag;
    logic [FX-1:0]     r_frac, n_frac;
    logic [54:0]       r_sv, n_sv, r_res, n_res, r_bit, n_bit;
    logic [26:0]       r_t, n_t;
    logic [29:0]       r_t2, n_t2;
    logic [32:0]       r_t3, n_t3;
    logic [VAL_W-1:0]  r_cur, n_cur, r_val, n_val;
    logic [50:0]       r_acc, n_acc;
    logic [VAL_W-1:0]  r_prev [MAX_DIMS];

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;

    // Working signals of the datapath.
    logic [31:0]       est, quo_dig;
    logic [ACC_W-1:0]  dig_r, digit, base;
    logic              dig_ge;
    logic [ACC_W:0]    rem_sh;
    logic              div_ge;
    logic [31:0]       h, pp, sq;
    logic [29:0]       lval;
    logic [5:0]        lint;
    logic [54:0]       sq_sum, res_nx;
    logic [32:0]       pshift, xdiff, xmag;
    logic [52:0]       rsum;
    logic [28:0]       rr;
    logic [VAL_W-1:0]  prev_sel;
    logic [32:0]       prev_mag, cur_mag;
    logic [50:0]       amag, p_signed;
    logic [34:0]       rs;
    logic              emit_fire;

    hgns_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign emit_fire = (r_state == S_EMIT) && i_emit_ready;

    // Radical-inverse digit: estimate from the reciprocal product, then one correction.
    always_comb begin
        base    = prime_of(r_dim);
        est     = prod[63:32];
        dig_r   = {3'b0, r_x} - mul_small({3'b0, est}, r_dim);
        dig_ge  = dig_r >= base;
        digit   = dig_ge ? (dig_r - base) : dig_r;
        quo_dig = dig_ge ? (est + 32'd1) : est;
    end

    // Shared restoring-division step and other single-step helpers.
    always_comb begin
        rem_sh   = {r_rem[ACC_W-1:0], r_dlow[31]};
        div_ge   = rem_sh >= {1'b0, r_den};
        h        = (r_quo == '0) ? 32'd1 : r_quo;
        pp       = h[31] ? 32'(33'h1_0000_0000 - {1'b0, h}) : h;
        sq       = prod[61:30];
        lint     = 6'd32 - {1'b0, r_e};
        lval     = {lint, 24'b0} - {6'b0, r_frac};
        sq_sum   = r_res + r_bit;
        res_nx   = (r_sv >= sq_sum) ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        pshift   = prod[56:24];
        xdiff    = {6'b0, r_t} - {1'b0, r_quo};
        xmag     = xdiff[32] ? (33'd0 - xdiff) : xdiff;
        rsum     = prod[52:0] + 53'h80_0000;
        rr       = rsum[52:24];
        prev_sel = r_prev[r_dim];
        prev_mag = prev_sel[31] ? (33'd0 - {1'b1, prev_sel}) : {1'b0, prev_sel};
        cur_mag  = r_cur[31] ? (33'd0 - {1'b1, r_cur}) : {1'b0, r_cur};
        p_signed = {2'b0, prod[48:0]};
        amag     = r_acc[50] ? (51'd0 - r_acc) : r_acc;
        rs       = 35'((amag + 51'h8000) >> 16);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_cmd.start) n_state = S_DIM_START;
            S_DIM_START: n_state = (r_idx == '0) ? S_DIV_INIT : S_RAD_MUL;
            S_RAD_MUL:   n_state = S_RAD_DIG;
            S_RAD_DIG:   n_state = (quo_dig == '0) ? S_DIV_INIT : S_RAD_MUL;
            S_DIV_INIT:  n_state = S_DIV;
            S_DIV:       if (r_cnt == 5'd31) n_state = r_phase ? S_FIN : S_INV_PREP;
            S_INV_PREP:  n_state = S_NORM;
            S_NORM:      if (r_m[31]) n_state = S_SQ_MUL;
            S_SQ_MUL:    n_state = S_SQ_POST;
            S_SQ_POST:   n_state = (r_cnt == 5'(FX-1)) ? S_LN_MUL : S_SQ_MUL;
            S_LN_MUL:    n_state = S_LN_POST;
            S_LN_POST:   n_state = S_SQRT;
            S_SQRT:      if (r_bit[0]) n_state = S_POLY;
            S_POLY:      if (r_cnt == POLY_LAST) n_state = S_DIV_INIT;
            S_FIN:       n_state = S_SIG_MUL;
            S_SIG_MUL:   n_state = S_SIG_POST;
            S_SIG_POST:  n_state = r_first ? S_EMIT : S_BL1;
            S_BL1:       n_state = S_BL2;
            S_BL2:       n_state = S_BL3;
            S_BL3:       n_state = S_BL_RND;
            S_BL_RND:    n_state = S_EMIT;
            S_EMIT: begin
                if (i_emit_ready) n_state = (r_dim == r_last_dim) ? S_IDLE : S_DIM_START;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb begin
        n_dim = r_dim;   n_last_dim = r_last_dim; n_first = r_first; n_idx = r_idx;
        n_phase = r_phase; n_neg = r_neg; n_zneg = r_zneg; n_x = r_x;
        n_dlow = r_dlow; n_quo = r_quo; n_num = r_num; n_den = r_den; n_rem = r_rem;
        n_cnt = r_cnt;   n_e = r_e;   n_m = r_m;   n_mag = r_mag; n_frac = r_frac;
        n_sv = r_sv;     n_res = r_res; n_bit = r_bit; n_t = r_t; n_t2 = r_t2;
        n_t3 = r_t3;     n_cur = r_cur; n_val = r_val; n_acc = r_acc;
        case (r_state)
            S_IDLE: begin
                n_dim      = '0;
                n_last_dim = i_cmd.last_dim;
                n_first    = i_cmd.first;
                n_idx      = i_cmd.idx;
            end
            S_DIM_START: begin
                n_x     = r_idx;
                n_num   = '0;
                n_den   = 35'd1;
                n_phase = 1'b0;
            end
            S_RAD_DIG: begin
                n_x   = quo_dig;
                n_num = mul_small(r_num, r_dim) + digit;
                n_den = mul_small(r_den, r_dim);
            end
            S_DIV_INIT: begin
                n_rem  = r_phase ? {12'b0, r_num[31:8]} : {1'b0, r_num};
                n_dlow = r_phase ? {r_num[7:0], 24'b0} : '0;
                n_quo  = '0;
                n_cnt  = '0;
            end
            S_DIV: begin
                n_rem  = div_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                n_quo  = {r_quo[30:0], div_ge};
                n_dlow = {r_dlow[30:0], 1'b0};
                n_cnt  = r_cnt + 5'd1;
            end
            S_INV_PREP: begin
                n_neg = !h[31];
                n_m   = pp;
                n_e   = 5'd31;
            end
            S_NORM: begin
                if (r_m[31]) begin
                    n_m    = {1'b0, r_m[31:1]};
                    n_cnt  = '0;
                    n_frac = '0;
                end else begin
                    n_m = {r_m[30:0], 1'b0};
                    n_e = r_e - 5'd1;
                end
            end
            S_SQ_POST: begin
                n_m    = sq[31] ? {1'b0, sq[31:1]} : sq;
                n_frac = {r_frac[FX-2:0], sq[31]};
                n_cnt  = r_cnt + 5'd1;
            end
            S_LN_POST: begin
                n_sv  = {1'b0, prod[61:32], 24'b0};
                n_res = '0;
                n_bit = {1'b1, 54'b0};
            end
            S_SQRT: begin
                if (r_sv >= sq_sum) n_sv = r_sv - sq_sum;
                n_res = res_nx;
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_t   = res_nx[26:0];
                    n_cnt = '0;
                    n_num = K_C0;
                    n_den = ONE_Q24;
                end
            end
            S_POLY: begin
                // Each step consumes the previous product and issues the next one.
                n_cnt = r_cnt + 5'd1;
                case (r_cnt)
                    5'd1:    n_t2 = pshift[29:0];
                    5'd2:    n_t3 = pshift;
                    5'd3:    n_num = r_num + {2'b0, pshift};
                    5'd4:    n_num = r_num + {2'b0, pshift};
                    5'd5:    n_den = r_den + {2'b0, pshift};
                    5'd6:    n_den = r_den + {2'b0, pshift};
                    5'd7:    n_den = r_den + {2'b0, pshift};
                    default: n_t2 = r_t2;
                endcase
                if (r_cnt == POLY_LAST) n_phase = 1'b1;
            end
            S_FIN: begin
                n_mag  = xmag[31:0];
                n_zneg = xdiff[32] ^ r_neg;
            end
            S_SIG_POST: begin
                n_cur = r_zneg ? (32'd0 - {3'b0, rr}) : {3'b0, rr};
                n_val = r_zneg ? (32'd0 - {3'b0, rr}) : {3'b0, rr};
            end
            S_BL2: begin
                n_acc = prev_sel[31] ? (51'd0 - p_signed) : p_signed;
            end
            S_BL3: begin
                n_acc = r_cur[31] ? (r_acc - p_signed) : (r_acc + p_signed);
            end
            S_BL_RND: begin
                // Round half away from zero, then saturate to 32 bits.
                if (!r_acc[50]) begin
                    n_val = (rs > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rs[31:0];
                end else begin
                    n_val = (rs > 35'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - rs[31:0]);
                end
            end
            S_EMIT: begin
                if (i_emit_ready) n_dim = r_dim + 2'd1;
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // Multiplier operands and result outputs.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_RAD_MUL: begin
                mul_a = {1'b0, r_x};
                mul_b = magic_of(r_dim);
            end
            S_SQ_MUL: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            S_LN_MUL: begin
                mul_a = {3'b0, lval};
                mul_b = TWO_LN2;
            end
            S_POLY: begin
                case (r_cnt)
                    5'd0:    begin mul_a = {6'b0, r_t}; mul_b = {6'b0, r_t}; end
                    5'd1:    begin mul_a = pshift;      mul_b = {6'b0, r_t}; end
                    5'd2:    begin mul_a = K_C1;        mul_b = {6'b0, r_t}; end
                    5'd3:    begin mul_a = K_C2;        mul_b = {3'b0, r_t2}; end
                    5'd4:    begin mul_a = K_D1;        mul_b = {6'b0, r_t}; end
                    5'd5:    begin mul_a = K_D2;        mul_b = {3'b0, r_t2}; end
                    5'd6:    begin mul_a = K_D3;        mul_b = r_t3; end
                    default: begin mul_a = '0;          mul_b = '0; end
                endcase
            end
            S_SIG_MUL: begin
                mul_a = {1'b0, r_mag};
                mul_b = {9'b0, i_sigma[r_dim]};
            end
            S_BL1: begin
                mul_a = {16'b0, i_decay};
                mul_b = prev_mag;
            end
            S_BL2: begin
                mul_a = {16'b0, i_diffusion};
                mul_b = cur_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        o_res.valid = (r_state == S_EMIT);
        o_res.dim   = r_dim;
        o_res.value = r_val;
        o_res.last  = (r_dim == r_last_dim);
        o_res.idle  = (r_state == S_IDLE);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dim   <= '0;
        end else begin
            r_state <= n_state;
            r_dim   <= n_dim;
        end
    end

    // Previous row, one value per dimension.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIMS; i++) r_prev[i] <= '0;
        end else if (emit_fire) begin
            r_prev[r_dim] <= r_val;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_last_dim <= n_last_dim; r_first <= n_first; r_idx <= n_idx; r_phase <= n_phase;
        r_neg  <= n_neg;  r_zneg <= n_zneg; r_x   <= n_x;   r_dlow <= n_dlow;
        r_quo  <= n_quo;  r_num  <= n_num;  r_den <= n_den; r_rem  <= n_rem;
        r_cnt  <= n_cnt;  r_e    <= n_e;    r_m   <= n_m;   r_mag  <= n_mag;
        r_frac <= n_frac; r_sv   <= n_sv;   r_res <= n_res; r_bit  <= n_bit;
        r_t    <= n_t;    r_t2   <= n_t2;   r_t3  <= n_t3;  r_cur  <= n_cur;
        r_val  <= n_val;  r_acc  <= n_acc;
    end

endmodule

### hw/rtl/hgns_checker.sv
// Port-level checker of the noise sampler, bound to the top level.
module hgns_checker
    import hgns_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [7:0]            i_s_axis_tdata,
    input logic                  i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [VAL_W-1:0]      o_m_axis_tdata,
    input logic [DIM_W-1:0]      o_m_axis_tuser,
    input logic                  o_m_axis_tlast,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result item changed");

    // No result item right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result item right after reset");

    // A produce request keeps the block busy in the following cycle.
    a_busy_after_produce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata[0] == OP_PRODUCE)
        |=> !o_s_axis_tready)
        else $error("ready right after a produce request");

    // While a row is incomplete, no new request is taken.
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("ready in the middle of a row");

endmodule

bind halton_gaussian_noise_sampler_unit hgns_checker u_hgns_checker (.*);

### sim/halton_gaussian_noise_sampler_unit_tb.sv
// Self-checking testbench of the Halton Gaussian noise sampler with its own row predictor.

// Predicts the noise rows of the sampler and checks every result item against them.
class halton_row_board;
    typedef struct {
        logic [1:0]  dim;
        logic [31:0] value;
        logic        last;
    } noise_item_t;

    noise_item_t     noise_q[$];
    int              errors;
    int              checked;
    // Mirrored configuration and state of the block.
    logic [2:0]      dim_count;
    logic [23:0]     sigma[4];
    logic [30:0]     seq_ofs;
    logic [16:0]     decay;
    logic [16:0]     diffusion;
    logic [31:0]     row_cnt;
    longint          prev_row[4];

    function new();
        dim_count = 3'd2;
        foreach (sigma[i]) begin
            sigma[i]    = 24'd65536;
            prev_row[i] = 0;
        end
        seq_ofs   = '0;
        decay     = '0;
        diffusion = 17'd65536;
        row_cnt   = '0;
        errors    = 0;
        checked   = 0;
    endfunction

    function int pending();
        return noise_q.size();
    endfunction

    function void write_cfg(logic [2:0] idx, logic [30:0] data);
        case (idx)
            hgns_pkg::CFG_DIM_COUNT: dim_count = data[2:0];
            hgns_pkg::CFG_SIGMA0:    sigma[0]  = data[23:0];
            hgns_pkg::CFG_SIGMA1:    sigma[1]  = data[23:0];
            hgns_pkg::CFG_SIGMA2:    sigma[2]  = data[23:0];
            hgns_pkg::CFG_SIGMA3:    sigma[3]  = data[23:0];
            hgns_pkg::CFG_SEQ_OFS:   seq_ofs   = data;
            hgns_pkg::CFG_DECAY:     decay     = data[16:0];
            default:                 diffusion = data[16:0];
        endcase
    endfunction

    // Radical inverse of idx in the given base, as Q0.32 by long division.
    function logic [31:0] radical_frac(longint unsigned idx, longint unsigned base);
        longint unsigned num, den, rem, q;
        num = 0;
        den = 1;
        q   = 0;
        while (idx > 0) begin
            num = num * base + idx % base;
            den = den * base;
            idx = idx / base;
        end
        rem = num;
        for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 1;
            end
        end
        return q[31:0];
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Rational inverse-normal approximation of a Q0.32 probability, result in Q.24.
    function longint gauss_q24(logic [31:0] h);
        bit              neg;
        longint unsigned pp, m, frac, lg, y, t, t2, t3, num, den, q;
        int              e;
        longint          x;
        if (h == 0) h = 1;
        neg  = h < 32'h8000_0000;
        pp   = neg ? 64'(h) : ((64'd1 << 32) - 64'(h));
        e    = 31;
        frac = 0;
        while (e > 0 && pp[e] == 1'b0) e--;
        m = (e > 30) ? (pp >> (e - 30)) : (pp << (30 - e));
        // Fraction bits of the logarithm by repeated squaring.
        for (int i = 0; i < 24; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        lg  = (64'(32 - e) << 24) - frac;
        y   = (lg * 64'(hgns_pkg::TWO_LN2)) >> 32;
        t   = int_sqrt(y << 24);
        t2  = (t * t) >> 24;
        t3  = (t2 * t) >> 24;
        num = 64'(hgns_pkg::K_C0) + ((64'(hgns_pkg::K_C1) * t) >> 24)
            + ((64'(hgns_pkg::K_C2) * t2) >> 24);
        den = (64'd1 << 24) + ((64'(hgns_pkg::K_D1) * t) >> 24)
            + ((64'(hgns_pkg::K_D2) * t2) >> 24) + ((64'(hgns_pkg::K_D3) * t3) >> 24);
        q   = (num << 24) / den;
        x   = longint'(t) - longint'(q);
        return neg ? -x : x;
    endfunction

    // Shift right rounding to nearest, ties away from zero.
    function longint round_away(longint v, int s);
        longint unsigned u;
        u = (v < 0) ? 64'(-v) : 64'(v);
        u = (u + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(u) : longint'(u);
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Accepted request: a clear resets the counter, a produce queues one row.
    function void note_request(logic op, logic first);
        int              n;
        longint unsigned idx;
        longint          v;
        noise_item_t     it;
        longint unsigned bases[4] = '{2, 3, 5, 7};
        if (op == hgns_pkg::OP_CLEAR) begin
            row_cnt = '0;
            return;
        end
        n   = (dim_count < 1) ? 1 : ((dim_count > 4) ? 4 : int'(dim_count));
        idx = (64'(seq_ofs) + 64'(row_cnt)) & 64'hFFFF_FFFF;
        for (int d = 0; d < n; d++) begin
            v = clamp32(round_away(gauss_q24(radical_frac(idx, bases[d])) *
                                   longint'(sigma[d]), 24));
            if (!first)
                v = clamp32(round_away(longint'(decay) * prev_row[d] +
                                       longint'(diffusion) * v, 16));
            prev_row[d] = v;
            it.dim   = d[1:0];
            it.value = v[31:0];
            it.last  = (d == n - 1);
            noise_q.insert(noise_q.size(), it);
        end
        row_cnt = row_cnt + 1;
    endfunction

    function void check_result(logic [1:0] dim, logic [31:0] value, logic last);
        noise_item_t e;
        checked++;
        if (noise_q.size() == 0) begin
            $display("%0t: unexpected item dim %0d value %h last %0b", $time, dim, value, last);
            errors++;
            return;
        end
        e = noise_q.pop_front();
        if (e.dim !== dim) begin
            $display("%0t: dim_index expected %0d actual %0d", $time, e.dim, dim);
            errors++;
        end
        if (e.value !== value) begin
            $display("%0t: noise_value (dim %0d) expected %h actual %h",
                     $time, e.dim, e.value, value);
            errors++;
        end
        if (e.last !== last) begin
            $display("%0t: last_of_row expected %0b actual %0b", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module halton_gaussian_noise_sampler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hgns_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [VAL_W-1:0]      o_m_axis_tdata;
    logic [DIM_W-1:0]      o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    halton_row_board board = new();
    bit  quiet = 1'b0;
    int  cycles = 0;
    int  rows_sent = 0;
    int  clears_sent = 0;

    halton_gaussian_noise_sampler_unit DUT (.*);

    always #10 i_clk = ~i_clk;

    // Result checking and the run-time guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items outstanding", $time, board.pending());
            $display("FAIL halton_gaussian_noise_sampler_unit");
            $finish;
        end
    end

    // Receiver stalls in random bursts until the quiet tail of the run.
    initial begin
        @(negedge i_clk);
        forever begin
            i_m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            if (!quiet) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
        end
    end

    // Presents one request and holds it until the block takes it.
    task automatic send_request(logic op, logic first);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'd0, op};
        i_s_axis_tuser  = first;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        board.note_request(op, first);
        if (op == OP_CLEAR) clears_sent++;
        else rows_sent++;
    endtask

    // Lowers valid and waits for every outstanding row to come back.
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        board.write_cfg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(logic [2:0] dims, logic [23:0] s0, logic [23:0] s1,
                             logic [23:0] s2, logic [23:0] s3, logic [30:0] ofs,
                             logic [16:0] dec, logic [16:0] dif);
        write_reg(CFG_DIM_COUNT, 31'(dims));
        write_reg(CFG_SIGMA0, 31'(s0));
        write_reg(CFG_SIGMA1, 31'(s1));
        write_reg(CFG_SIGMA2, 31'(s2));
        write_reg(CFG_SIGMA3, 31'(s3));
        write_reg(CFG_SEQ_OFS, ofs);
        write_reg(CFG_DECAY, 31'(dec));
        write_reg(CFG_DIFFUSION, 31'(dif));
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: index zero, blending disabled, a clear mid-trajectory.
        send_request(OP_PRODUCE, 1'b1);
        send_request(OP_PRODUCE, 1'b0);
        send_request(OP_PRODUCE, 1'b0);
        send_request(OP_CLEAR, 1'b1);
        send_request(OP_PRODUCE, 1'b0);
        send_request(OP_CLEAR, 1'b0);
        drain();

        // Largest scales, full decay and diffusion: values saturate.
        write_all(3'd4, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  31'h7FFF_FFFF, 17'd65536, 17'd65536);
        send_request(OP_PRODUCE, 1'b1);
        repeat (4) send_request(OP_PRODUCE, 1'b0);
        drain();

        // Zero dimension count acts as one; zero scale; all-ones decay, no diffusion.
        write_all(3'd0, 24'd0, 24'd0, 24'd0, 24'd0, 31'd0, 17'h1FFFF, 17'd0);
        send_request(OP_PRODUCE, 1'b1);
        send_request(OP_PRODUCE, 1'b0);
        drain();

        // Dimension count above the maximum, mixed scales with a live blend.
        write_all(3'd7, 24'd65536, 24'd131072, 24'd32768, 24'h800000,
                  31'd12345, 17'd52429, 17'h1FFFF);
        send_request(OP_PRODUCE, 1'b1);
        repeat (3) send_request(OP_PRODUCE, 1'b0);
        send_request(OP_CLEAR, 1'b1);
        send_request(OP_PRODUCE, 1'b0);
        drain();

        // Random settings, each followed by trajectories of random length.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) quiet = 1'b1;
            write_all(3'($urandom_range(0, 7)), 24'($urandom), 24'($urandom),
                      24'($urandom), 24'($urandom),
                      ($urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 300))),
                      17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
            for (int k = 0; k < 24; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(OP_CLEAR, 1'($urandom));
                else
                    send_request(OP_PRODUCE, ($urandom_range(0, 5) == 0));
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        $display("Covered %0d noise rows and %0d counter clears, %0d result items checked",
                 rows_sent, clears_sent, board.checked);
        $display("over register extremes, saturation, blending and random settings.");
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS halton_gaussian_noise_sampler_unit");
        else
            $display("FAIL halton_gaussian_noise_sampler_unit");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/hgns_pkg.sv
hw/rtl/hgns_mul.sv
hw/rtl/hgns_core.sv
hw/rtl/halton_gaussian_noise_sampler_unit.sv
hw/rtl/hgns_checker.sv
sim/halton_gaussian_noise_sampler_unit_tb.sv
